### sv/ads_pkg.sv
// Shared types, constants and helper functions for the antenna deployment sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ads_pkg;

    // Width of the tick, minute and hour counters.
    localparam int COUNT_BITS = 16;
    // Width of the configuration counts.
    localparam int CFG_CNT_BITS = 16;
    // Common width for comparing a counter against a configured count.
    localparam int CMP_BITS = (COUNT_BITS > CFG_CNT_BITS) ? COUNT_BITS : CFG_CNT_BITS;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_BITS-1:0] CFG_COLD_TEMP  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SUN_CUR    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_WAIT_TICKS = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TICKS_MIN  = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MIN_HOUR   = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_INT_HOURS  = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_EXP_TICKS  = 3'd6;

    // Request kinds carried on the input tuser bit.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_BOOT = 1'b1;

    typedef enum logic [1:0] {
        MODE_WAIT     = 2'd0,
        MODE_INTERVAL = 2'd1,
        MODE_EXPAND   = 2'd2,
        MODE_SKIP     = 2'd3
    } t_mode;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic [7:0]              cold_temp_threshold;
        logic [7:0]              sun_current_threshold;
        logic [CFG_CNT_BITS-1:0] wait_ticks;
        logic [CFG_CNT_BITS-1:0] ticks_per_minute;
        logic [CFG_CNT_BITS-1:0] minutes_per_hour;
        logic [CFG_CNT_BITS-1:0] interval_hours;
        logic [CFG_CNT_BITS-1:0] expand_ticks;
    } t_cfg;

    typedef struct packed {
        t_mode  mode;
        t_count tick_count;
        t_count minute_count;
        t_count hour_count;
        logic   done_flag;
        logic   drive_level;
    } t_state;

    typedef struct packed {
        logic       req_type;
        logic [7:0] temp_a;
        logic [7:0] temp_b;
        logic [7:0] temp_c;
        logic [7:0] panel_current;
        logic       done_request;
        logic       stored_expanded;
    } t_item;

    typedef struct packed {
        logic  reinit_system;
        logic  mark_expanded;
        logic  heater_restore;
        logic  heater_off;
        logic  antenna_drive;
        t_mode mode;
    } t_result;

    // Saturating increment: holds at all ones instead of wrapping.
    function automatic t_count sat_inc(input t_count v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [CMP_BITS-1:0] ext_cnt(input t_count v);
        return CMP_BITS'(v);
    endfunction

    function automatic logic [CMP_BITS-1:0] ext_cfg(input logic [CFG_CNT_BITS-1:0] v);
        return CMP_BITS'(v);
    endfunction

endpackage

### sv/ads_step.sv
// Next-state and result logic for one sequencer step.
// Depends on ads_pkg for the state, item, configuration and result types.
`timescale 1ns / 1ps

module ads_step (
    input  ads_pkg::t_state  i_state,
    input  ads_pkg::t_cfg    i_cfg,
    input  ads_pkg::t_item   i_item,
    output ads_pkg::t_state  o_state,
    output ads_pkg::t_result o_result
);

    logic cold_a;
    logic cold_b;
    logic cold_c;
    logic qualify;
    logic done_now;
    ads_pkg::t_state  ns;
    ads_pkg::t_result res;

    // A tick qualifies when at least two of three sensors are cold and the panels see sun.
    assign cold_a  = i_item.temp_a < i_cfg.cold_temp_threshold;
    assign cold_b  = i_item.temp_b < i_cfg.cold_temp_threshold;
    assign cold_c  = i_item.temp_c < i_cfg.cold_temp_threshold;
    assign qualify = ((cold_a & cold_b) | (cold_a & cold_c) | (cold_b & cold_c))
                   & (i_item.panel_current > i_cfg.sun_current_threshold);

    assign done_now = i_state.done_flag | i_item.done_request;

    always_comb begin
        ns           = i_state;
        ns.done_flag = done_now;
        res          = '0;

        priority if (i_item.req_type == ads_pkg::REQ_BOOT) begin
            if (i_item.stored_expanded) begin
                ns.mode       = ads_pkg::MODE_WAIT;
                ns.tick_count = '0;
            end else begin
                ns.mode = ads_pkg::MODE_SKIP;
            end
        end else begin
            unique case (i_state.mode)
                ads_pkg::MODE_WAIT: begin
                    if (qualify) begin
                        ns.tick_count = ads_pkg::sat_inc(i_state.tick_count);
                    end
                    if (ads_pkg::ext_cnt(ns.tick_count) > ads_pkg::ext_cfg(i_cfg.wait_ticks)) begin
                        ns.mode       = ads_pkg::MODE_EXPAND;
                        ns.tick_count = '0;
                    end
                end
                ads_pkg::MODE_INTERVAL: begin
                    if (qualify) begin
                        ns.tick_count = ads_pkg::sat_inc(i_state.tick_count);
                    end
                    if (done_now) begin
                        ns.mode         = ads_pkg::MODE_SKIP;
                        ns.tick_count   = '0;
                        ns.minute_count = '0;
                        ns.hour_count   = '0;
                        res.mark_expanded = 1'b1;
                    end
                    // The minute, hour and deploy checks still run after a done request.
                    if (ads_pkg::ext_cnt(ns.tick_count)
                            > ads_pkg::ext_cfg(i_cfg.ticks_per_minute)) begin
                        ns.minute_count = ads_pkg::sat_inc(ns.minute_count);
                        ns.tick_count   = '0;
                    end
                    if (ads_pkg::ext_cnt(ns.minute_count)
                            >= ads_pkg::ext_cfg(i_cfg.minutes_per_hour)) begin
                        ns.hour_count   = ads_pkg::sat_inc(ns.hour_count);
                        ns.tick_count   = '0;
                        ns.minute_count = '0;
                    end
                    if (ads_pkg::ext_cnt(ns.hour_count)
                            >= ads_pkg::ext_cfg(i_cfg.interval_hours)) begin
                        ns.mode         = ads_pkg::MODE_EXPAND;
                        ns.tick_count   = '0;
                        ns.minute_count = '0;
                        ns.hour_count   = '0;
                    end
                end
                ads_pkg::MODE_EXPAND: begin
                    res.heater_off = 1'b1;
                    ns.tick_count  = ads_pkg::sat_inc(i_state.tick_count);
                    ns.drive_level = 1'b1;
                    if (i_item.panel_current < i_cfg.sun_current_threshold) begin
                        ns.tick_count      = '0;
                        ns.drive_level     = 1'b0;
                        ns.mode            = ads_pkg::MODE_WAIT;
                        res.heater_restore = 1'b1;
                    end
                    // An abort clears the count, so this only fires on a full run.
                    if (ads_pkg::ext_cnt(ns.tick_count) > ads_pkg::ext_cfg(i_cfg.expand_ticks)) begin
                        res.reinit_system = 1'b1;
                        ns.mode           = ads_pkg::MODE_INTERVAL;
                        ns.tick_count     = '0;
                        ns.minute_count   = '0;
                        ns.hour_count     = '0;
                        ns.done_flag      = 1'b0;
                        ns.drive_level    = 1'b0;
                    end
                end
                ads_pkg::MODE_SKIP: begin
                    ns.mode = ads_pkg::MODE_SKIP;
                end
                default: begin
                    ns.mode = i_state.mode;
                end
            endcase
        end

        res.mode          = ns.mode;
        res.antenna_drive = ns.drive_level;
    end

    assign o_state  = ns;
    assign o_result = res;

endmodule

### sv/antenna_deploy_sequencer.sv
// Throughput: one transaction per cycle while i_m_tready is high; the step logic sits
// between an input register and an output register, and the sequencer state updates in
// the same cycle as the result.
// Reset: synchronous, active low; the sequencer returns to interval mode with all counters,
// the done flag and the drive level cleared, and all thresholds return to their defaults.
// Depends on ads_pkg and ads_step.
`timescale 1ns / 1ps

module antenna_deploy_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata, from bit 0: temp_a[7:0], temp_b[15:8], temp_c[23:16], panel_current[31:24],
    // done_request[32], stored_expanded[33], zero fill[39:34].
    input  logic [39:0] i_s_tdata,
    // tuser: req_type[0] (0 periodic tick, 1 boot check).
    input  logic        i_s_tuser,

    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata, from bit 0: mode[1:0], antenna_drive[2], heater_off[3], heater_restore[4],
    // mark_expanded[5], reinit_system[6], zero fill[7].
    output logic [7:0]  o_m_tdata,

    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ads_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [ads_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    // Input stage: holds one accepted transaction until the step logic consumes it.
    logic            r_in_valid;
    ads_pkg::t_item  r_in_item;

    // Output stage: the finished result waits here for the downstream ready.
    logic             r_out_valid;
    ads_pkg::t_result r_out_data;

    // Sequencer state and configuration registers.
    ads_pkg::t_state  r_state;
    ads_pkg::t_cfg    r_cfg;

    ads_pkg::t_state  n_state;
    ads_pkg::t_result n_result;

    logic s_in_accept;
    logic s_advance;

    // The step fires when the input stage holds an item and the output stage is free
    // or being drained this cycle, so a stalled output still leaves room for one item.
    assign s_advance   = r_in_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready  = ~r_in_valid | s_advance;
    assign s_in_accept = i_s_tvalid & o_s_tready;

    // Configuration writes are always accepted and are registered directly into r_cfg.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_accept) begin
            r_in_item.req_type        <= i_s_tuser;
            r_in_item.temp_a          <= i_s_tdata[7:0];
            r_in_item.temp_b          <= i_s_tdata[15:8];
            r_in_item.temp_c          <= i_s_tdata[23:16];
            r_in_item.panel_current   <= i_s_tdata[31:24];
            r_in_item.done_request    <= i_s_tdata[32];
            r_in_item.stored_expanded <= i_s_tdata[33];
        end
    end

    ads_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // State moves only when a step fires, in the same edge that captures its result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode         <= ads_pkg::MODE_INTERVAL;
            r_state.tick_count   <= '0;
            r_state.minute_count <= '0;
            r_state.hour_count   <= '0;
            r_state.done_flag    <= 1'b0;
            r_state.drive_level  <= 1'b0;
        end else if (s_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_advance) begin
            r_out_data <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0,
                         r_out_data.reinit_system,
                         r_out_data.mark_expanded,
                         r_out_data.heater_restore,
                         r_out_data.heater_off,
                         r_out_data.antenna_drive,
                         r_out_data.mode};

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cold_temp_threshold   <= 8'd20;
            r_cfg.sun_current_threshold <= 8'd50;
            r_cfg.wait_ticks            <= 16'd600;
            r_cfg.ticks_per_minute      <= 16'd60;
            r_cfg.minutes_per_hour      <= 16'd60;
            r_cfg.interval_hours        <= 16'd24;
            r_cfg.expand_ticks          <= 16'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                ads_pkg::CFG_COLD_TEMP:  r_cfg.cold_temp_threshold   <= i_cfg_data[7:0];
                ads_pkg::CFG_SUN_CUR:    r_cfg.sun_current_threshold <= i_cfg_data[7:0];
                ads_pkg::CFG_WAIT_TICKS: r_cfg.wait_ticks            <= i_cfg_data;
                ads_pkg::CFG_TICKS_MIN:  r_cfg.ticks_per_minute      <= i_cfg_data;
                ads_pkg::CFG_MIN_HOUR:   r_cfg.minutes_per_hour      <= i_cfg_data;
                ads_pkg::CFG_INT_HOURS:  r_cfg.interval_hours        <= i_cfg_data;
                ads_pkg::CFG_EXP_TICKS:  r_cfg.expand_ticks          <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

endmodule

### sv/ads_checker.sv
// Port-level checks for the antenna deployment sequencer, bound to its top level.
// Depends on ads_pkg for the mode codes.
`timescale 1ns / 1ps

module ads_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);

    // A stalled result stays put.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("result changed while stalled");

    // A finished deployment returns to interval mode with the drive released and the heater off.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[6]) |->
            (o_m_tdata[1:0] == ads_pkg::MODE_INTERVAL && !o_m_tdata[2] && o_m_tdata[3]))
        else $error("reinit without returning to interval");

    // An abort happens only in expand, drops the drive and lands in wait.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[4]) |->
            (o_m_tdata[3] && !o_m_tdata[2] && o_m_tdata[1:0] == ads_pkg::MODE_WAIT
             && !o_m_tdata[6]))
        else $error("bad abort result");

    // An expand step that neither aborts nor finishes keeps driving in expand mode.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[3] && !o_m_tdata[4] && !o_m_tdata[6]) |->
            (o_m_tdata[2] && o_m_tdata[1:0] == ads_pkg::MODE_EXPAND))
        else $error("expand step lost the drive");

    // Marking expanded leaves interval for skip, or for expand when the hour limit fires.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[5]) |->
            (o_m_tdata[1:0] == ads_pkg::MODE_SKIP || o_m_tdata[1:0] == ads_pkg::MODE_EXPAND))
        else $error("mark without leaving interval");

endmodule

bind antenna_deploy_sequencer ads_checker u_ads_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
